// ----- rtl/core/lstm_pkg.sv -----
// Shared types and constants for the linear sieve totient and Mobius block.
`timescale 1ns / 1ps
package lstm_pkg;

  localparam int LIMIT_W = 17;
  localparam int NUMBER_W = 17;
  localparam int TOT_W = 16;
  localparam int MOB_W = 2;
  localparam int MAX_NUMBER_DEF = 65536;
  localparam int MAX_PRIMES_DEF = 8192;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

  localparam logic [MOB_W-1:0] MOB_ZERO = 2'b00;
  localparam logic [MOB_W-1:0] MOB_ONE = 2'b01;
  localparam logic [MOB_W-1:0] MOB_NEG = 2'b11;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_PRD,
    S_PCAP,
    S_PCMP,
    S_PDIV,
    S_PWR,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ONE,
    OUT_NUM,
    OUT_BEY
  } out_kind_e;

  typedef struct packed {
    logic      clr_step;
    logic      load_item;
    logic      chk;
    logic      p_cap;
    logic      div_start;
    logic      div_cap;
    logic      wr_prod;
    logic      out_load;
    out_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic first;
    logic beyond;
    logic j_end;
    logic over;
    logic div_done;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/linear_sieve_totient_mobius.sv -----
// Top level of the linear sieve: one integer with totient, Mobius value and prime flag per beat.
// A first-n or beyond-limit beat goes straight to the output; a restart sweeps the marks first.
// Other beats walk the prime list with a bit-serial remainder per prime that marks a product
// (NUM_W, the width of MAX_NUMBER, sets the remainder) and stop at the end of the prime list,
// at a product past the limit or at a prime that divides the number; a stalled output register
// holds the next beat off. Reset sweeps the marks; a beat can go in the cycle after a result.
`timescale 1ns / 1ps
module linear_sieve_totient_mobius import lstm_pkg::*; #(
  parameter int MAX_NUMBER = MAX_NUMBER_DEF,
  parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    restart_i,
  input  logic                    cfg_we_i,
  input  logic [LIMIT_W-1:0]      cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [NUMBER_W-1:0]     number_o,
  output logic [TOT_W-1:0]        totient_o,
  output logic signed [MOB_W-1:0] mobius_o,
  output logic                    is_prime_o,
  output logic                    beyond_limit_o
);

  cmd_t    cmd;
  status_t st;

  lstm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .restart_i, .st_i(st), .cmd_o(cmd), .in_stall_o
  );

  lstm_dp #(.MAX_NUMBER(MAX_NUMBER), .MAX_PRIMES(MAX_PRIMES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st), .restart_i, .cfg_we_i, .cfg_data_i,
    .out_stall_i, .out_valid_o, .number_o, .totient_o, .mobius_o, .is_prime_o,
    .beyond_limit_o
  );

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item was still in work");

  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beyond_limit_o |-> number_o == '0 && totient_o == '0 && !is_prime_o)
    else $error("beyond-limit beat carries data");

  a_prime_mobius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_prime_o |-> mobius_o == MOB_NEG && !beyond_limit_o)
    else $error("prime beat without Mobius -1");
`endif

endmodule

// ----- rtl/core/lstm_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lstm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/lstm_mod.sv -----
// Bit-serial remainder unit that reports whether a dividend is a multiple of a divisor.
`timescale 1ns / 1ps
module lstm_mod #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic         rem_zero_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     sh_q, sh_d;
  logic [W-1:0]     div_q, div_d;
  logic [W:0]       trial;

  assign trial = {rem_q, sh_q[W-1]};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d  = CNT_W'(W);
      busy_d = 1'b1;
      rem_d  = '0;
      sh_d   = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = W'(trial - {1'b0, div_q});
      end else begin
        rem_d = W'(trial);
      end
      sh_d  = {sh_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    div_q <= div_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign rem_zero_o = (rem_q == '0);

endmodule

// ----- rtl/core/lstm_dp.sv -----
// Sieve datapath: stores, counters, product and totient arithmetic, output register.
`timescale 1ns / 1ps
module lstm_dp import lstm_pkg::*; #(
  parameter int MAX_NUMBER = MAX_NUMBER_DEF,
  parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    st_o,
  input  logic                       restart_i,
  input  logic                       cfg_we_i,
  input  logic [LIMIT_W-1:0]         cfg_data_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [NUMBER_W-1:0]        number_o,
  output logic [TOT_W-1:0]           totient_o,
  output logic signed [MOB_W-1:0]    mobius_o,
  output logic                       is_prime_o,
  output logic                       beyond_limit_o
);

  localparam int NUM_W = $clog2(MAX_NUMBER + 1);
  localparam int PC_W = $clog2(MAX_PRIMES + 1);
  localparam int PA_W = $clog2(MAX_PRIMES);
  localparam int CW = (NUM_W > LIMIT_W) ? NUM_W : LIMIT_W;
  localparam int PROD_W = 2 * NUM_W;

  logic [LIMIT_W-1:0] limit_q;
  logic [NUM_W-1:0]   cur_q, n_q, clr_q, p_q;
  logic [PC_W-1:0]    pc_q, j_q;
  logic [PROD_W-1:0]  prod_q;
  logic [TOT_W-1:0]   tot_n_q, totp_q;
  logic [MOB_W-1:0]   mob_n_q;
  logic               prime_q, rz_q, out_valid_q;

  logic [CW-1:0]      lim_x, max_x;
  logic [NUM_W-1:0]   eff;
  logic [NUM_W:0]     n_next;
  logic               mark_rd;
  logic [TOT_W-1:0]   tot_rd;
  logic [MOB_W-1:0]   mob_rd;
  logic [NUM_W-1:0]   prime_rd;
  logic               div_done, rem_zero;
  logic [TOT_W-1:0]   fac;
  logic [2*TOT_W-1:0] tot_full;
  logic               is_new_prime;

  assign lim_x  = CW'(limit_q);
  assign max_x  = CW'(MAX_NUMBER);
  assign eff    = NUM_W'((lim_x > max_x) ? max_x : lim_x);
  assign n_next = {1'b0, cur_q} + 1'b1;
  assign is_new_prime = cmd_i.chk && !mark_rd;

  // Composite marks: cleared by the sweep, set at each product.
  logic             mark_we;
  logic [NUM_W-1:0] mark_wa;
  assign mark_we = cmd_i.clr_step || cmd_i.wr_prod;
  assign mark_wa = cmd_i.clr_step ? clr_q : prod_q[NUM_W-1:0];

  lstm_ram #(.WIDTH(1), .DEPTH(MAX_NUMBER + 1)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(cmd_i.wr_prod),
    .raddr_i(n_q), .rdata_o(mark_rd)
  );

  logic             val_we;
  logic [NUM_W-1:0] val_wa;
  logic [TOT_W-1:0] tot_wd;
  logic [MOB_W-1:0] mob_wd;
  assign val_we = is_new_prime || cmd_i.wr_prod;
  assign val_wa = cmd_i.wr_prod ? prod_q[NUM_W-1:0] : n_q;
  assign tot_wd = cmd_i.wr_prod ? totp_q : TOT_W'(n_q - 1'b1);
  assign mob_wd = cmd_i.wr_prod ? (rz_q ? MOB_ZERO : MOB_W'(-mob_n_q)) : MOB_NEG;

  lstm_ram #(.WIDTH(TOT_W), .DEPTH(MAX_NUMBER + 1)) u_tot (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(tot_wd),
    .raddr_i(n_q), .rdata_o(tot_rd)
  );

  lstm_ram #(.WIDTH(MOB_W), .DEPTH(MAX_NUMBER + 1)) u_mob (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(mob_wd),
    .raddr_i(n_q), .rdata_o(mob_rd)
  );

  logic prime_we;
  assign prime_we = is_new_prime && (pc_q < PC_W'(MAX_PRIMES));

  lstm_ram #(.WIDTH(NUM_W), .DEPTH(MAX_PRIMES)) u_prime (
    .clk_i, .we_i(prime_we), .waddr_i(pc_q[PA_W-1:0]), .wdata_i(n_q),
    .raddr_i(j_q[PA_W-1:0]), .rdata_o(prime_rd)
  );

  lstm_mod #(.W(NUM_W)) u_mod (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(n_q), .divisor_i(p_q),
    .done_o(div_done), .rem_zero_o(rem_zero)
  );

  assign fac      = rem_zero ? TOT_W'(p_q) : TOT_W'(p_q - 1'b1);
  assign tot_full = tot_n_q * fac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      cur_q       <= '0;
      pc_q        <= '0;
      clr_q       <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load_item) begin
        if (restart_i) begin
          pc_q  <= '0;
          cur_q <= NUM_W'(1);
          clr_q <= '0;
        end else if (cur_q == '0) begin
          cur_q <= NUM_W'(1);
        end else if (n_next <= {1'b0, eff}) begin
          cur_q <= NUM_W'(n_next);
        end
      end
      if (prime_we) begin
        pc_q <= pc_q + 1'b1;
      end
      if (cmd_i.chk) begin
        j_q <= '0;
      end else if (cmd_i.wr_prod) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      n_q <= NUM_W'(n_next);
    end
    if (cmd_i.chk) begin
      prime_q <= !mark_rd;
      tot_n_q <= mark_rd ? tot_rd : TOT_W'(n_q - 1'b1);
      mob_n_q <= mark_rd ? mob_rd : MOB_NEG;
    end
    if (cmd_i.p_cap) begin
      p_q    <= prime_rd;
      prod_q <= n_q * prime_rd;
    end
    if (cmd_i.div_cap) begin
      rz_q   <= rem_zero;
      totp_q <= tot_full[TOT_W-1:0];
    end
    if (cmd_i.out_load) begin
      case (cmd_i.kind)
        OUT_ONE: begin
          number_o       <= NUMBER_W'(1);
          totient_o      <= TOT_W'(1);
          mobius_o       <= MOB_ONE;
          is_prime_o     <= 1'b0;
          beyond_limit_o <= 1'b0;
        end
        OUT_NUM: begin
          number_o       <= NUMBER_W'(n_q);
          totient_o      <= tot_n_q;
          mobius_o       <= mob_n_q;
          is_prime_o     <= prime_q;
          beyond_limit_o <= 1'b0;
        end
        default: begin
          number_o       <= '0;
          totient_o      <= '0;
          mobius_o       <= MOB_ZERO;
          is_prime_o     <= 1'b0;
          beyond_limit_o <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign st_o.clr_last  = (clr_q == NUM_W'(MAX_NUMBER));
  assign st_o.first     = (cur_q == '0);
  assign st_o.beyond    = (n_next > {1'b0, eff});
  assign st_o.j_end     = (j_q == pc_q);
  assign st_o.over      = (prod_q > PROD_W'(eff));
  assign st_o.div_done  = div_done;
  assign st_o.rem_zero  = rz_q;
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

// ----- rtl/core/lstm_ctrl.sv -----
// Sieve controller state machine that sequences the datapath for each item.
`timescale 1ns / 1ps
module lstm_ctrl import lstm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    restart_i,
  input  status_t st_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o
);

  state_e    state_q, state_d;
  out_kind_e kind_q, kind_d;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      S_CLEAR: begin
        if (st_i.clr_last) begin
          state_d = (kind_q == OUT_NONE) ? S_IDLE : S_EMIT;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            state_d = S_CLEAR;
            kind_d  = OUT_ONE;
          end else if (st_i.first) begin
            state_d = S_EMIT;
            kind_d  = OUT_ONE;
          end else if (st_i.beyond) begin
            state_d = S_EMIT;
            kind_d  = OUT_BEY;
          end else begin
            state_d = S_RD;
            kind_d  = OUT_NUM;
          end
        end
      end
      S_RD:   state_d = S_CHK;
      S_CHK:  state_d = S_PRD;
      S_PRD:  state_d = st_i.j_end ? S_EMIT : S_PCAP;
      S_PCAP: state_d = S_PCMP;
      S_PCMP: state_d = st_i.over ? S_EMIT : S_PDIV;
      S_PDIV: begin
        if (st_i.div_done) begin
          state_d = S_PWR;
        end
      end
      // The smallest prime factor ends the walk once it has been used.
      S_PWR:  state_d = st_i.rem_zero ? S_EMIT : S_PRD;
      S_EMIT: begin
        if (st_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = kind_q;
    cmd_o.clr_step  = (state_q == S_CLEAR);
    cmd_o.load_item = (state_q == S_IDLE) && in_valid_i;
    cmd_o.chk       = (state_q == S_CHK);
    cmd_o.p_cap     = (state_q == S_PCAP);
    cmd_o.div_start = (state_q == S_PCMP) && !st_i.over;
    cmd_o.div_cap   = (state_q == S_PDIV) && st_i.div_done;
    cmd_o.wr_prod   = (state_q == S_PWR);
    cmd_o.out_load  = (state_q == S_EMIT) && st_i.out_free;
    in_stall_o      = (state_q != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= OUT_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ----- sim/linear_sieve_totient_mobius_test.sv -----
// Self-checking testbench for the linear sieve totient and Mobius block.
`timescale 1ns / 1ps
module linear_sieve_totient_mobius_test;
  import lstm_pkg::*;

  localparam int SIEVE_MAX = MAX_NUMBER_DEF;
  localparam int PRIME_MAX = MAX_PRIMES_DEF;

  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic [TOT_W-1:0]    totient;
    logic [MOB_W-1:0]    mobius;
    logic                is_prime;
    logic                beyond;
  } sieve_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic restart_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [NUMBER_W-1:0] number_o;
  logic [TOT_W-1:0] totient_o;
  logic signed [MOB_W-1:0] mobius_o;
  logic is_prime_o;
  logic beyond_limit_o;

  always #5 clk_i = ~clk_i;

  linear_sieve_totient_mobius u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .restart_i,
    .cfg_we_i, .cfg_data_i, .out_valid_o, .out_stall_i,
    .number_o, .totient_o, .mobius_o, .is_prime_o, .beyond_limit_o
  );

  // Private copy of the sieve state.
  bit          marked[0:SIEVE_MAX];
  int unsigned phi_tab[0:SIEVE_MAX];
  logic [1:0]  mu_tab[0:SIEVE_MAX];
  int unsigned primes[PRIME_MAX];
  int unsigned n_primes;
  int unsigned n_cur;
  int unsigned sieve_limit = LIMIT_RESET;

  bit         restart_q[$];
  sieve_out_t sieve_expect[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_beyond = 0;
  int n_prime_seen = 0;
  int n_restarts = 0;

  function automatic logic [1:0] mu_neg(logic [1:0] m);
    return (m == MOB_ONE) ? MOB_NEG : (m == MOB_NEG) ? MOB_ONE : MOB_ZERO;
  endfunction

  function automatic sieve_out_t sieve_next(bit restart);
    longint unsigned eff, n, p, prod;
    bit prime;
    sieve_out_t r;
    eff = (sieve_limit > SIEVE_MAX) ? SIEVE_MAX : sieve_limit;
    prime = 1'b0;
    r = '0;
    if (restart) begin
      foreach (marked[k]) marked[k] = 1'b0;
      n_primes = 0;
      n_cur = 0;
    end
    n = n_cur + 1;
    if (n == 1) begin
      phi_tab[1] = 1;
      mu_tab[1] = MOB_ONE;
      n_cur = 1;
      r.number = 1;
      r.totient = 1;
      r.mobius = MOB_ONE;
      return r;
    end
    if (n > eff) begin
      r.beyond = 1'b1;
      return r;
    end
    n_cur = n;
    if (!marked[n]) begin
      prime = 1'b1;
      phi_tab[n] = n - 1;
      mu_tab[n] = MOB_NEG;
      if (n_primes < PRIME_MAX) begin
        primes[n_primes] = n;
        n_primes++;
      end
    end
    for (int j = 0; j < n_primes; j++) begin
      p = primes[j];
      prod = n * p;
      if (prod > eff) break;
      marked[prod] = 1'b1;
      if (n % p != 0) begin
        phi_tab[prod] = phi_tab[n] * (p - 1);
        mu_tab[prod] = mu_neg(mu_tab[n]);
      end else begin
        phi_tab[prod] = phi_tab[n] * p;
        mu_tab[prod] = MOB_ZERO;
        break;
      end
    end
    r.number = n;
    r.totient = phi_tab[n];
    r.mobius = mu_tab[n];
    r.is_prime = prime;
    return r;
  endfunction

  // Driver: bursts of beats separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sieve_expect = {sieve_expect, sieve_next(restart_i)};
        n_items++;
        if (restart_i) n_restarts++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (restart_q.size() > 0) begin
          in_valid_i <= 1'b1;
          restart_i <= restart_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: runs of stalled or open cycles of random length.
  int stall_run = 0;
  bit stall_on = 1'b0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_on = ($urandom_range(0, 2) == 0);
      stall_run = stall_on ? $urandom_range(1, 5) : $urandom_range(1, 30);
    end
    stall_run--;
    out_stall_i <= stall_on;
  end

  // Monitor.
  always @(posedge clk_i) begin
    sieve_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (sieve_expect.size() == 0) begin
        $error("result with nothing expected: number %0d", number_o);
        errors++;
      end else begin
        want = sieve_expect.pop_front();
        if (beyond_limit_o) n_beyond++;
        if (is_prime_o) n_prime_seen++;
        if (number_o !== want.number) begin
          $error("number: expected %0d, got %0d", want.number, number_o);
          errors++;
        end
        if (totient_o !== want.totient) begin
          $error("totient: expected %0d, got %0d", want.totient, totient_o);
          errors++;
        end
        if (mobius_o !== want.mobius) begin
          $error("mobius: expected %0d, got %0d", $signed(want.mobius), mobius_o);
          errors++;
        end
        if (is_prime_o !== want.is_prime) begin
          $error("is_prime: expected %0d, got %0d", want.is_prime, is_prime_o);
          errors++;
        end
        if (beyond_limit_o !== want.beyond) begin
          $error("beyond_limit: expected %0d, got %0d", want.beyond, beyond_limit_o);
          errors++;
        end
      end
    end
  end

  // Sampled at the falling edge so that a beat launched at the last rising edge is seen.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (restart_q.size() != 0 || in_valid_i || sieve_expect.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(int unsigned value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= LIMIT_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sieve_limit = value & 32'h1FFFF;
  endtask

  task automatic queue_run(bit restart, int count);
    restart_q = {restart_q, restart};
    for (int k = 1; k < count; k++) restart_q = {restart_q, 1'b0};
  endtask

  initial begin
    int unsigned lim_pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first item without restart, small n covering primes, squares,
    // squarefree composites, then a restart.
    queue_run(1'b0, 12);
    queue_run(1'b1, 3);
    // Limit below 2: only n=1 is reported, everything after is beyond.
    set_limit(0);
    queue_run(1'b1, 3);
    set_limit(1);
    queue_run(1'b0, 1);
    // Smallest legal limit, then raised mid-run without a restart.
    set_limit(2);
    queue_run(1'b0, 3);
    set_limit(10);
    queue_run(1'b0, 4);
    // Above the sieve size acts as the full size.
    set_limit(17'h1FFFF);
    queue_run(1'b0, 4);

    // Random phases; restarts are costly, so only some phases begin with one.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lim_pick = 65536;
        1: lim_pick = $urandom_range(2, 60);
        2: lim_pick = 17'h1FFFF;
        3: lim_pick = $urandom_range(100, 3000);
        4: lim_pick = 2;
        default: lim_pick = $urandom_range(2, 65536);
      endcase
      set_limit(lim_pick);
      queue_run(ph inside {0, 1, 3} || $urandom_range(0, 1), ph == 4 ? 30 : 230);
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items (%0d restarts), %0d results: %0d primes, %0d beyond limit.",
             n_items, n_restarts, n_results, n_prime_seen, n_beyond);
    if (errors == 0 && sieve_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sieve_expect.size() != 0) $error("%0d results never arrived", sieve_expect.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out waiting for the block.");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lstm_pkg.sv
rtl/core/lstm_ram.sv
rtl/core/lstm_mod.sv
rtl/core/lstm_dp.sv
rtl/core/lstm_ctrl.sv
rtl/core/linear_sieve_totient_mobius.sv
sim/linear_sieve_totient_mobius_test.sv
